// File: rtl/core/assert_macros.svh
// Assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define CLF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define CLF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CLF_ASSERT(label, prop, msg)
`define CLF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/core/clf_pkg.sv
package clf_pkg;

   // Significant bits of a request length.
   localparam int COUNT_WIDTH = 16;
   localparam logic [15:0] COUNT_MASK =
      (COUNT_WIDTH >= 16) ? 16'hFFFF : 16'((1 << COUNT_WIDTH) - 1);

   typedef enum logic [2:0] {
      CMD_OPEN_REQ   = 3'd0,
      CMD_CLOSE_REQ  = 3'd1,
      CMD_WRITE_REQ  = 3'd2,
      CMD_READ_REQ   = 3'd3,
      CMD_OPEN_DONE  = 3'd4,
      CMD_READ_DONE  = 3'd5,
      CMD_WRITE_DONE = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_BAD_ARG = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ACT_NONE        = 3'd0,
      ACT_START_OPEN  = 3'd1,
      ACT_CLOSE       = 3'd2,
      ACT_ABORT_OPEN  = 3'd3,
      ACT_START_WRITE = 3'd4,
      ACT_START_READ  = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      NTF_NONE        = 3'd0,
      NTF_LAYER_UP    = 3'd1,
      NTF_OPEN_FAILED = 3'd2,
      NTF_LAYER_DOWN  = 3'd3,
      NTF_SEND_DONE   = 3'd4,
      NTF_DATA_RECV   = 3'd5
   } notify_type;

   // Bit 0 is open, bit 4 is closing.
   typedef struct packed {
      logic closing;
      logic writing;
      logic reading;
      logic opening;
      logic open;
   } flags_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        error;
      logic [15:0] byte_count;
      logic [31:0] buffer_ref;
   } req_type;

   typedef struct packed {
      status_type  status;
      action_type  action;
      notify_type  note;
      logic [31:0] buffer_out;
      logic [15:0] count_out;
      flags_type   flags;
   } rsp_type;

endpackage

// File: rtl/core/clf_step.sv
// One event against the current flags: guard checks, flag update, outputs.
module clf_step (
   input  clf_pkg::flags_type flags,
   input  logic               notify_enable,
   input  clf_pkg::req_type   req,
   output clf_pkg::rsp_type   rsp
);

   function automatic logic close_ready(clf_pkg::flags_type f);
      close_ready = f.closing && !(f.opening || f.reading || f.writing);
   endfunction

   function automatic logic may_close(clf_pkg::flags_type f);
      may_close = (f.open || f.opening) && !f.closing;
   endfunction

   clf_pkg::flags_type   f;
   clf_pkg::status_type  status;
   clf_pkg::action_type  action;
   clf_pkg::notify_type  note;
   logic [31:0]          bout;
   logic [15:0]          cout;
   logic [15:0]          cnt;
   logic                 busy;

   always_comb begin
      f      = flags;
      status = clf_pkg::ST_OK;
      action = clf_pkg::ACT_NONE;
      note   = clf_pkg::NTF_NONE;
      bout   = '0;
      cout   = '0;
      cnt    = req.byte_count & clf_pkg::COUNT_MASK;
      busy   = 1'b0;

      case (clf_pkg::cmd_type'(req.cmd))
         clf_pkg::CMD_OPEN_REQ: begin
            if (f == '0) begin
               f.opening = 1'b1;
               action    = clf_pkg::ACT_START_OPEN;
            end else begin
               status = clf_pkg::ST_INVALID;
            end
         end
         clf_pkg::CMD_CLOSE_REQ: begin
            if (!f.closing) begin
               if (may_close(f)) begin
                  f.closing = 1'b1;
                  action    = f.opening ? clf_pkg::ACT_ABORT_OPEN : clf_pkg::ACT_CLOSE;
               end else begin
                  status = clf_pkg::ST_INVALID;
               end
            end
            if (status == clf_pkg::ST_OK && close_ready(f)) begin
               f.closing = 1'b0;
               f.open    = 1'b0;
               note      = clf_pkg::NTF_LAYER_DOWN;
            end
         end
         clf_pkg::CMD_WRITE_REQ, clf_pkg::CMD_READ_REQ: begin
            busy = (req.cmd == clf_pkg::CMD_WRITE_REQ) ? f.writing : f.reading;
            if (cnt == '0) begin
               status = clf_pkg::ST_BAD_ARG;
            end else if (f.open && !f.closing && !busy) begin
               if (req.cmd == clf_pkg::CMD_WRITE_REQ) begin
                  f.writing = 1'b1;
                  action    = clf_pkg::ACT_START_WRITE;
               end else begin
                  f.reading = 1'b1;
                  action    = clf_pkg::ACT_START_READ;
               end
               bout = req.buffer_ref;
               cout = cnt;
            end else begin
               status = clf_pkg::ST_INVALID;
            end
         end
         clf_pkg::CMD_OPEN_DONE: begin
            if (f.opening) begin
               f.opening = 1'b0;
               if (req.error || f.closing) begin
                  // failed open, or open finished under a pending close
                  if (close_ready(f)) begin
                     f.closing = 1'b0;
                     f.open    = 1'b0;
                  end
                  note = clf_pkg::NTF_OPEN_FAILED;
                  if (!req.error) action = clf_pkg::ACT_CLOSE;
               end else begin
                  f.open = 1'b1;
                  note   = clf_pkg::NTF_LAYER_UP;
               end
            end else begin
               status = clf_pkg::ST_INVALID;
            end
         end
         clf_pkg::CMD_READ_DONE, clf_pkg::CMD_WRITE_DONE: begin
            busy = (req.cmd == clf_pkg::CMD_WRITE_DONE) ? f.writing : f.reading;
            if (busy) begin
               if (req.cmd == clf_pkg::CMD_WRITE_DONE) f.writing = 1'b0;
               else                                    f.reading = 1'b0;
               if (req.error) begin
                  if (may_close(f)) begin
                     f.closing = 1'b1;
                     action    = f.opening ? clf_pkg::ACT_ABORT_OPEN : clf_pkg::ACT_CLOSE;
                  end
               end else if (!f.closing) begin
                  if (req.cmd == clf_pkg::CMD_READ_DONE) begin
                     note = clf_pkg::NTF_DATA_RECV;
                     bout = req.buffer_ref;
                     cout = cnt;
                  end else begin
                     note = clf_pkg::NTF_SEND_DONE;
                  end
               end
               if (close_ready(f)) begin
                  f.closing = 1'b0;
                  f.open    = 1'b0;
                  note      = clf_pkg::NTF_LAYER_DOWN;
               end
            end else begin
               status = clf_pkg::ST_INVALID;
            end
         end
         default: begin
            status = clf_pkg::ST_BAD_ARG;
         end
      endcase

      // rejected: flags stay, nothing started or raised
      if (status != clf_pkg::ST_OK) begin
         f      = flags;
         action = clf_pkg::ACT_NONE;
         note   = clf_pkg::NTF_NONE;
         bout   = '0;
         cout   = '0;
      end

      // no upper handler: drop the notice and its data
      if (!notify_enable) begin
         if (note == clf_pkg::NTF_DATA_RECV) begin
            bout = '0;
            cout = '0;
         end
         note = clf_pkg::NTF_NONE;
      end

      rsp.status     = status;
      rsp.action     = action;
      rsp.note       = note;
      rsp.buffer_out = bout;
      rsp.count_out  = cout;
      rsp.flags      = f;
   end

endmodule

// File: rtl/core/channel_lifecycle_fsm.sv
// Channel    | Handshake               | Carries
// -----------+-------------------------+----------------------------------------
// req_       | req_valid / req_ready   | event: cmd, error, byte_count, buffer_ref
// rsp_       | rsp_valid / rsp_ready   | status, action, notify, buffer, count, flags
// csr_       | csr_write_enable        | notify_enable (1 bit), no read-back
//
// One request per cycle sustained while rsp_ready is high; a request passes the
// input register, then the result register that drives rsp_valid. The flag update
// sits in the single combinational step between those two registers, so back-to-back
// requests see the flags of the one before. Synchronous active-high reset clears
// both valid bits, the flags (channel closed) and notify_enable. A stalled rsp_ready
// holds the result; req_ready drops only once the input register is also full.

`include "assert_macros.svh"

module channel_lifecycle_fsm (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic        req_error,
   input  logic [15:0] req_byte_count,
   input  logic [31:0] req_buffer_ref,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_lower_action,
   output logic [2:0]  rsp_notify,
   output logic [31:0] rsp_buffer_out,
   output logic [15:0] rsp_count_out,
   output logic [4:0]  rsp_flags_out,

   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   // input stage
   logic              in_valid_ff;
   logic              in_valid_in;
   clf_pkg::req_type  in_req_ff;

   // result stage
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   clf_pkg::rsp_type  rsp_ff;
   clf_pkg::rsp_type  step_rsp;

   // channel state
   clf_pkg::flags_type flags_ff;
   clf_pkg::flags_type flags_in;
   logic               notify_enable_ff;

   logic              advance;   // input stage moves into result stage

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign flags_in     = advance ? step_rsp.flags : flags_ff;

   clf_step u_step (
      .flags         (flags_ff),
      .notify_enable (notify_enable_ff),
      .req           (in_req_ff),
      .rsp           (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         flags_ff         <= '0;
         notify_enable_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
         if (csr_write_enable) notify_enable_ff <= csr_write_data;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff.cmd        <= req_cmd;
         in_req_ff.error      <= req_error;
         in_req_ff.byte_count <= req_byte_count;
         in_req_ff.buffer_ref <= req_buffer_ref;
      end
      if (advance) rsp_ff <= step_rsp;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_lower_action = rsp_ff.action;
   assign rsp_notify       = rsp_ff.note;
   assign rsp_buffer_out   = rsp_ff.buffer_out;
   assign rsp_count_out    = rsp_ff.count_out;
   assign rsp_flags_out    = rsp_ff.flags;

   // terms for the checks below
   logic rsp_rejected;
   logic rsp_quiet;
   logic xfer_pending;
   logic pipe_full;

   assign rsp_rejected = rsp_valid_ff && (rsp_ff.status != clf_pkg::ST_OK);
   assign rsp_quiet    = (rsp_ff.action == clf_pkg::ACT_NONE)
                         && (rsp_ff.note == clf_pkg::NTF_NONE);
   assign xfer_pending = flags_ff.reading || flags_ff.writing;
   assign pipe_full    = in_valid_ff && rsp_valid_ff && !rsp_ready;

   // a rejected request never starts or raises anything
   `CLF_ASSERT(a_reject_quiet, rsp_rejected |-> rsp_quiet, "rejected request with action or notice")
   // open and opening are never both set
   `CLF_ASSERT(a_open_excl, !(flags_ff.open && flags_ff.opening), "open and opening set together")
   // a transfer in flight implies the channel is open
   `CLF_ASSERT(a_xfer_open, xfer_pending |-> flags_ff.open, "transfer pending while not open")
   // back-pressure only when both stages hold a request
   `CLF_ASSERT(a_ready_full, !req_ready |-> pipe_full, "req_ready low with room in the pipeline")

endmodule
